// ===== rtl/core/rc4_pkg.sv =====
package rc4_pkg;

   // Permutation table geometry.
   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);

   // Key storage: four 64-bit key words hold up to 32 key bytes.
   localparam int KEY_WORD_W    = 64;
   localparam int KEY_WORDS     = 4;
   localparam int KEY_BYTES     = KEY_WORDS * KEY_WORD_W / 8;
   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int LEN_W         = KEY_IDX_W + 1;
   localparam int KEY_LEN_W     = 6;
   localparam int KEY_LEN_RESET = 16;

   // Register file port.
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_LEN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD_N,
      ST_KS_RD_J,
      ST_KS_WR_J,
      ST_KS_WR_N,
      ST_PG_RD_I,
      ST_PG_RD_J,
      ST_PG_WR_I,
      ST_PG_WR_J,
      ST_HOLD
   } state_type;

endpackage

// ===== rtl/core/rc4_stream_cipher_core.sv =====
// RC4 stream cipher core. Each word on the request stream carries one data byte
// in req_tdata and an end-of-message flag in req_tlast; each response word
// carries that byte XORed with the next keystream byte, with tlast copied
// through. Encryption and decryption are the same operation. The first word of
// every message (the first after reset, and every word that follows one with
// tlast set) starts a fresh key schedule: the 256-entry permutation table is
// filled with the identity and then scrambled by 256 swap steps, and only then
// does that word get its own swap and keystream read. For every later word of
// the message the acceptance cycle also issues the first table read. The
// read-read-write-write swap and the keystream read share the single read and
// single write port of the table. The key is held in key_word_0..3 (byte n at
// word n/8, bits 8*(n%8) and up) and key_len; a length of zero counts as one
// and lengths above 32 saturate. The key is sampled only during a schedule, so
// a change takes effect with the next message. Registers sit at byte addresses
// 8*i in register order and must be written only while the core is idle. A
// finished result waits in the output register while the core is ready for the
// next word; if that register is still full, the result waits in ST_HOLD and
// the core takes no request word until the register is free.
module rc4_stream_cipher_core (
   input  logic                              clock,
   input  logic                              reset,

   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_in
   input  logic                              req_tlast,  // message_last

   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [7:0] data_out
   output logic                              rsp_tlast,  // result_last

   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rc4_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rc4_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   import rc4_pkg::*;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                 state_ff, state_in;

   logic [KEY_LEN_W-1:0]      key_len_ff;
   logic [KEY_WORD_W-1:0]     key_word_ff [KEY_WORDS];

   logic [IDX_W-1:0]          index_i_ff, index_i_in;
   logic [IDX_W-1:0]          index_j_ff, index_j_in;
   logic                      needs_sched_ff, needs_sched_in;

   // Schedule counters: table position, running sum, key byte position.
   logic [IDX_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          acc_ff, acc_in;
   logic [KEY_IDX_W-1:0]      key_idx_ff, key_idx_in;

   // Operands of the swap in flight and the keystream address.
   logic [IDX_W-1:0]          val_a_ff, val_a_in;
   logic [IDX_W-1:0]          val_b_ff, val_b_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;

   logic [7:0]                data_ff, data_in;
   logic                      last_ff, last_in;
   logic [7:0]                hold_ff, hold_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Permutation table with one write and one registered read port.
   logic [IDX_W-1:0]          perm_mem [TABLE_SIZE];
   logic [IDX_W-1:0]          rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          wr_data;

   // ------------------------------------------------------------------
   // Combinational helpers
   // ------------------------------------------------------------------
   logic                      req_accept;
   logic                      out_free;
   logic                      csr_write;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [LEN_W-1:0]          eff_len;
   logic [KEY_WORDS*KEY_WORD_W-1:0] key_vec;
   logic [7:0]                key_byte;
   logic [IDX_W-1:0]          ks_byte;
   logic [IDX_W-1:0]          sum_j;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:3];

   always_comb begin
      case (csr_index)
         REG_KEY_LEN:    csr_prdata = {{(CSR_DATA_W-KEY_LEN_W){1'b0}}, key_len_ff};
         REG_KEY_WORD_0: csr_prdata = key_word_ff[0];
         REG_KEY_WORD_1: csr_prdata = key_word_ff[1];
         REG_KEY_WORD_2: csr_prdata = key_word_ff[2];
         REG_KEY_WORD_3: csr_prdata = key_word_ff[3];
         default:        csr_prdata = '0;
      endcase
   end

   // Effective key length: zero counts as one, long keys saturate.
   always_comb begin
      if (key_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (int'(key_len_ff) > MAX_KEY_BYTES) begin
         eff_len = LEN_W'(MAX_KEY_BYTES);
      end else begin
         eff_len = LEN_W'(key_len_ff);
      end
   end

   assign key_vec = {key_word_ff[3], key_word_ff[2], key_word_ff[1], key_word_ff[0]};

   // Key bytes past the key words read as zero.
   always_comb begin
      if (int'(key_idx_ff) < KEY_BYTES) begin
         key_byte = key_vec[{key_idx_ff, 3'b000} +: 8];
      end else begin
         key_byte = '0;
      end
   end

   // Running sum of the key schedule step: acc + S[n] + key byte.
   assign sum_j = acc_ff + rd_data_ff + key_byte;

   // After the swap S[i] holds the old S[j] and S[j] the old S[i]; the
   // keystream read was issued in the same cycle as the write to S[i], so
   // both swapped entries are forwarded here.
   always_comb begin
      if (addr_ff == index_j_ff) begin
         ks_byte = val_a_ff;
      end else if (addr_ff == index_i_ff) begin
         ks_byte = val_b_ff;
      end else begin
         ks_byte = rd_data_ff;
      end
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = needs_sched_ff ? ST_INIT : ST_PG_RD_J;
            end
         end
         ST_INIT: begin
            if (count_ff == IDX_W'(TABLE_SIZE - 1)) begin
               state_in = ST_KS_RD_N;
            end
         end
         ST_KS_RD_N: state_in = ST_KS_RD_J;
         ST_KS_RD_J: state_in = ST_KS_WR_J;
         ST_KS_WR_J: state_in = ST_KS_WR_N;
         ST_KS_WR_N: begin
            state_in = (count_ff == IDX_W'(TABLE_SIZE - 1)) ? ST_PG_RD_I : ST_KS_RD_N;
         end
         ST_PG_RD_I: state_in = ST_PG_RD_J;
         ST_PG_RD_J: state_in = ST_PG_WR_I;
         ST_PG_WR_I: state_in = ST_PG_WR_J;
         ST_PG_WR_J: state_in = out_free ? ST_IDLE : ST_HOLD;
         ST_HOLD:    state_in = out_free ? ST_IDLE : ST_HOLD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath and table controls
   // ------------------------------------------------------------------
   always_comb begin
      index_i_in     = index_i_ff;
      index_j_in     = index_j_ff;
      needs_sched_in = needs_sched_ff;
      count_in       = count_ff;
      acc_in         = acc_ff;
      key_idx_in     = key_idx_ff;
      val_a_in       = val_a_ff;
      val_b_in       = val_b_ff;
      addr_in        = addr_ff;
      data_in        = data_ff;
      last_in        = last_ff;
      hold_in        = hold_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rd_addr        = index_i_ff + IDX_W'(1);
      wr_en          = 1'b0;
      wr_addr        = count_ff;
      wr_data        = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               data_in        = req_tdata;
               last_in        = req_tlast;
               needs_sched_in = req_tlast;
               count_in       = '0;
               // Without a schedule, the read of S[i+1] goes out right away.
               if (!needs_sched_ff) begin
                  index_i_in = index_i_ff + IDX_W'(1);
               end
            end
         end
         ST_INIT: begin
            wr_en      = 1'b1;
            count_in   = count_ff + IDX_W'(1);
            acc_in     = '0;
            key_idx_in = '0;
         end
         ST_KS_RD_N: begin
            rd_addr = count_ff;
         end
         ST_KS_RD_J: begin
            val_a_in = rd_data_ff;
            acc_in   = sum_j;
            addr_in  = sum_j;
            rd_addr  = sum_j;
         end
         ST_KS_WR_J: begin
            wr_en    = 1'b1;
            wr_addr  = addr_ff;
            wr_data  = val_a_ff;
            val_b_in = rd_data_ff;
         end
         ST_KS_WR_N: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff;
            wr_data  = val_b_ff;
            count_in = count_ff + IDX_W'(1);
            if ({1'b0, key_idx_ff} + LEN_W'(1) == eff_len) begin
               key_idx_in = '0;
            end else begin
               key_idx_in = key_idx_ff + KEY_IDX_W'(1);
            end
            if (count_ff == IDX_W'(TABLE_SIZE - 1)) begin
               index_i_in = '0;
               index_j_in = '0;
            end
         end
         ST_PG_RD_I: begin
            rd_addr    = index_i_ff + IDX_W'(1);
            index_i_in = index_i_ff + IDX_W'(1);
         end
         ST_PG_RD_J: begin
            val_a_in   = rd_data_ff;
            index_j_in = index_j_ff + rd_data_ff;
            rd_addr    = index_j_ff + rd_data_ff;
         end
         ST_PG_WR_I: begin
            val_b_in = rd_data_ff;
            wr_en    = 1'b1;
            wr_addr  = index_i_ff;
            wr_data  = rd_data_ff;
            addr_in  = val_a_ff + rd_data_ff;
            rd_addr  = val_a_ff + rd_data_ff;
         end
         ST_PG_WR_J: begin
            wr_en   = 1'b1;
            wr_addr = index_j_ff;
            wr_data = val_a_ff;
            hold_in = data_ff ^ ks_byte;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff ^ ks_byte;
               rsp_last_in  = last_ff;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               rsp_last_in  = last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Permutation table
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= perm_mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Control and configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         index_i_ff     <= '0;
         index_j_ff     <= '0;
         needs_sched_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         acc_ff         <= '0;
         key_idx_ff     <= '0;
         key_len_ff     <= KEY_LEN_W'(KEY_LEN_RESET);
         for (int w = 0; w < KEY_WORDS; w++) begin
            key_word_ff[w] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         index_i_ff     <= index_i_in;
         index_j_ff     <= index_j_in;
         needs_sched_ff <= needs_sched_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         acc_ff         <= acc_in;
         key_idx_ff     <= key_idx_in;
         if (csr_write) begin
            case (csr_index)
               REG_KEY_LEN:    key_len_ff     <= csr_pwdata[KEY_LEN_W-1:0];
               REG_KEY_WORD_0: key_word_ff[0] <= csr_pwdata;
               REG_KEY_WORD_1: key_word_ff[1] <= csr_pwdata;
               REG_KEY_WORD_2: key_word_ff[2] <= csr_pwdata;
               REG_KEY_WORD_3: key_word_ff[3] <= csr_pwdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      val_a_ff    <= val_a_in;
      val_b_ff    <= val_b_in;
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== test/rc4_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port. It keeps its own copy of the
// key registers and of the RC4 permutation state, and predicts every response
// word from the request words that are accepted.
module rc4_stream_checker (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   input  logic                           req_tlast,

   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [7:0]                     rsp_tdata,
   input  logic                           rsp_tlast,

   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [rc4_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rc4_pkg::CSR_DATA_W-1:0] csr_pwdata,

   output int                             fail_count,
   output int                             backlog
);

   import rc4_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } cipher_word_type;

   cipher_word_type         pending_words[$];

   logic [KEY_LEN_W-1:0]    key_len_q;
   logic [KEY_WORD_W-1:0]   key_word_q [KEY_WORDS];
   logic [7:0]              sbox [TABLE_SIZE];
   logic [7:0]              idx_i;
   logic [7:0]              idx_j;
   logic                    schedule_due;
   int                      errors = 0;

   function automatic void swap_sbox(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] t;
      t       = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = t;
   endfunction

   // Identity fill followed by the 256 key-driven swaps.
   function automatic void run_key_schedule();
      int         len;
      int         n;
      int         k;
      logic [7:0] acc;
      logic [7:0] kbyte;
      len = key_len_q;
      if (len < 1) len = 1;
      if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
      for (n = 0; n < TABLE_SIZE; n++) sbox[n] = 8'(n);
      acc = 8'd0;
      for (n = 0; n < TABLE_SIZE; n++) begin
         k = n % len;
         if (k < KEY_BYTES) kbyte = key_word_q[k / 8][8 * (k % 8) +: 8];
         else kbyte = 8'd0;
         acc = acc + sbox[n] + kbyte;
         swap_sbox(8'(n), acc);
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
   endfunction

   function automatic logic [7:0] next_keystream();
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox[idx_i];
      swap_sbox(idx_i, idx_j);
      return sbox[8'(sbox[idx_i] + sbox[idx_j])];
   endfunction

   always @(posedge clock) begin
      cipher_word_type want;
      cipher_word_type got;
      if (reset) begin
         pending_words.delete();
         key_len_q = KEY_LEN_W'(KEY_LEN_RESET);
         foreach (key_word_q[w]) key_word_q[w] = '0;
         idx_i        = 8'd0;
         idx_j        = 8'd0;
         schedule_due = 1'b1;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:3])
               REG_KEY_LEN:    key_len_q     = csr_pwdata[KEY_LEN_W-1:0];
               REG_KEY_WORD_0: key_word_q[0] = csr_pwdata;
               REG_KEY_WORD_1: key_word_q[1] = csr_pwdata;
               REG_KEY_WORD_2: key_word_q[2] = csr_pwdata;
               REG_KEY_WORD_3: key_word_q[3] = csr_pwdata;
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.data = rsp_tdata;
            got.last = rsp_tlast;
            if (pending_words.size() == 0) begin
               $error("unexpected response word: data_out %02h, result_last %0b",
                      got.data, got.last);
               errors++;
            end else begin
               want = pending_words.pop_front();
               if (got.data !== want.data) begin
                  $error("data_out: expected %02h, actual %02h", want.data, got.data);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("result_last: expected %0b, actual %0b", want.last, got.last);
                  errors++;
               end
            end
         end

         // The key is sampled only when a message starts.
         if (req_tvalid && req_tready) begin
            if (schedule_due) begin
               run_key_schedule();
               schedule_due = 1'b0;
            end
            want.data = req_tdata ^ next_keystream();
            want.last = req_tlast;
            pending_words.push_back(want);
            if (req_tlast) schedule_due = 1'b1;
         end
      end
      fail_count <= errors;
      backlog    <= pending_words.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the RC4 core test. This module only makes stimulus and gives the
// verdict; the checker beside the core predicts and compares every word.
module tb_top;
   import rc4_pkg::*;

   // A word that starts a message waits out the whole key schedule, so the
   // watchdog must allow well beyond that.
   localparam int QUIET_LIMIT       = 6000;
   localparam int HOLD_CYCLES       = 400;
   localparam int WORDS_PER_PHASE   = 200;
   localparam int DRAIN_CYCLES      = 20;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;

   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'd0;   // [7:0] data_in
   logic                  req_tlast   = 1'b0;   // message_last

   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [7:0]            rsp_tdata;            // [7:0] data_out
   logic                  rsp_tlast;            // result_last

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    backlog;

   // Idle controls for the current phase, in percent of cycles.
   int                    send_gap_pct  = 0;
   int                    rsp_stall_pct = 0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit                    hold_rsp      = 1'b0;
   int                    quiet_cycles  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rc4_stream_cipher_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rc4_stream_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .backlog     (backlog)
   );

   // Receiver. It stalls at the rate of the current phase. When asked, it
   // holds tready low for a long stretch that it counts itself, so that the
   // core's output register fills and the core stops taking request words.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: any accepted word or register access counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("rc4_stream_cipher_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request word, after a random gap, and returns at the edge
   // that accepts it. Valid is left high so back-to-back words stay dense.
   task automatic send_word(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering words and waits until every predicted word has come out.
   // Used both as a mid-message pause and before register writes.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (backlog == 0);
      @(posedge clock);
   endtask

   // One register write: setup cycle, access cycle, then an idle gap so that a
   // following write starts in a later time step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_key(input int len, input logic [KEY_WORD_W-1:0] w0,
                            input logic [KEY_WORD_W-1:0] w1,
                            input logic [KEY_WORD_W-1:0] w2,
                            input logic [KEY_WORD_W-1:0] w3);
      write_reg(REG_KEY_LEN, CSR_DATA_W'(len));
      write_reg(REG_KEY_WORD_0, w0);
      write_reg(REG_KEY_WORD_1, w1);
      write_reg(REG_KEY_WORD_2, w2);
      write_reg(REG_KEY_WORD_3, w3);
   endtask

   function automatic logic [KEY_WORD_W-1:0] random_key_word();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly legal key lengths, now and then zero or a length that saturates.
   task automatic random_key();
      int pick;
      int len;
      pick = $urandom_range(9);
      if (pick == 0) len = 0;
      else if (pick == 1) len = $urandom_range(33, 63);
      else len = $urandom_range(1, 32);
      write_key(len, random_key_word(), random_key_word(), random_key_word(),
                random_key_word());
   endtask

   task automatic send_message(input int count);
      int k;
      for (k = 0; k < count; k++) send_word(8'($urandom_range(255)), k == count - 1);
   endtask

   initial begin
      int phase;
      int sent;
      int count;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset key: length 16 with all key bytes zero.
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hA5, 1'b1);
      drain();

      // A key length of zero behaves as a one-byte key.
      write_key(0, random_key_word(), random_key_word(), random_key_word(),
                random_key_word());
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      drain();

      // Shortest and longest keys with every key bit set, including a
      // message of a single word.
      write_key(1, '1, '1, '1, '1);
      send_word(8'h5A, 1'b1);
      drain();
      write_reg(REG_KEY_LEN, CSR_DATA_W'(MAX_KEY_BYTES));
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h3C, 1'b1);
      drain();

      // Lengths above the maximum saturate, both just above and at the top
      // of the register's range.
      write_key(63, random_key_word(), random_key_word(), random_key_word(),
                random_key_word());
      send_message(2);
      drain();
      write_reg(REG_KEY_LEN, CSR_DATA_W'(33));
      send_message(2);

      // A key change in the middle of a message must not touch the running
      // keystream; the new key takes effect with the next message. The pause
      // also lets every expected word come out before the sender goes on.
      drain();
      write_key(8, random_key_word(), random_key_word(), random_key_word(),
                random_key_word());
      send_word(8'($urandom_range(255)), 1'b0);
      send_word(8'($urandom_range(255)), 1'b0);
      drain();
      write_reg(REG_KEY_WORD_0, random_key_word());
      write_reg(REG_KEY_LEN, CSR_DATA_W'(5));
      send_word(8'($urandom_range(255)), 1'b0);
      send_word(8'($urandom_range(255)), 1'b1);
      send_message(2);
      drain();

      // Random part, one phase per idle setting.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 70; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 70; end
            default: begin send_gap_pct = 18; rsp_stall_pct = 18; end
         endcase
         random_key();
         sent = 0;

         if (phase == 0) begin
            // Back pressure: a few words get through, then the receiver holds
            // off while the sender keeps offering the rest of the message.
            send_message(3);
            send_word(8'($urandom_range(255)), 1'b0);
            send_word(8'($urandom_range(255)), 1'b0);
            hold_rsp = 1'b1;
            send_message(20);
            // A message long enough for both indices to wrap around.
            send_message(270);
            sent += 295;
         end

         while (sent < WORDS_PER_PHASE) begin
            if ($urandom_range(7) == 0) count = $urandom_range(40, 60);
            else count = $urandom_range(1, 16);
            send_message(count);
            sent += count;
            if ($urandom_range(7) == 0) begin
               drain();
               random_key();
            end
         end
         drain();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (backlog == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("rc4_stream_cipher_core: match");
      else $display("rc4_stream_cipher_core: mismatch");
      $finish;
   end

endmodule
